[sv/dcpid_pkg.sv]
// Shared types and constants for the dual channel PID regulator.
// No dependencies; imported by the regulator and its checker.
`default_nettype none

package dcpid_pkg;

   // Width of the per-channel integral accumulator, signed Q12.12
   localparam int unsigned INTEG_W = 24;

   // Width of the gain and limit registers
   localparam int unsigned CSR_DATA_W  = 16;
   localparam int unsigned CSR_INDEX_W = 3;

   // Reset values of the configuration registers
   localparam logic [CSR_DATA_W-1:0] PROP_GAIN_RST  = 16'd2867;   // about 0.7 in Q4.12
   localparam logic [CSR_DATA_W-1:0] INTEG_GAIN_RST = 16'd41;     // about 0.01 in Q4.12
   localparam logic [CSR_DATA_W-1:0] DERIV_GAIN_RST = 16'd1024;   // 0.25 in Q4.12
   localparam logic [CSR_DATA_W-1:0] OUT_MAX_RST    = 16'd25600;  // 100.0 in Q8.8
   localparam logic [CSR_DATA_W-1:0] OUT_MIN_RST    = 16'd0;

   // Configuration register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PROP_GAIN  = 3'd0,
      CSR_INTEG_GAIN = 3'd1,
      CSR_DERIV_GAIN = 3'd2,
      CSR_OUT_MAX    = 3'd3,
      CSR_OUT_MIN    = 3'd4
   } csr_index_type;

   // Request operation codes
   typedef enum logic {
      OP_STEP  = 1'b0,
      OP_CLEAR = 1'b1
   } op_type;

   // Limit status reported with each result
   typedef enum logic [1:0] {
      LIMIT_NONE = 2'd0,
      LIMIT_HIGH = 2'd1,
      LIMIT_LOW  = 2'd2
   } limit_type;

endpackage

`default_nettype wire

[sv/dual_channel_pid_antiwindup.sv]
// Dual channel PID regulator with anti-windup clamp, top level.
// Depends on dcpid_pkg for register indexes, operation and status codes.
`default_nettype none

// Takes one transaction per cycle on the req_ channel while req_stall is low, and
// returns one result per transaction on the rsp_ channel, in order, by way of the
// input and result registers. A transaction is held in an input register; one pass
// of logic (three multipliers, rounding, the sum and the limit compare) reads the
// selected channel's integral and last measurement, and writes the updated state
// together with the result register at the same edge, so a transaction for the
// same channel in the very next cycle already sees the new state. The result
// register lets the next transaction in while a result waits on rsp_stall.
// csr_ready is always high; write gains and limits only while no transaction is
// in flight.
module dual_channel_pid_antiwindup
   import dcpid_pkg::*;
#(
   parameter int NUM_CHANNELS = 2,
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_operation,
   input  logic                           req_channel,
   input  logic signed [SAMPLE_WIDTH-1:0] req_error_value,
   input  logic signed [SAMPLE_WIDTH-1:0] req_measurement,
   // result channel
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_drive,
   output logic [1:0]                     rsp_limit_status,
   // configuration write channel
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [CSR_INDEX_W-1:0]         csr_index,
   input  logic [CSR_DATA_W-1:0]          csr_wdata
);

   localparam int SW    = SAMPLE_WIDTH;
   localparam int CH_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   // integral plus increment, one guard bit
   localparam int ACC_W = (((SW + 10) > INTEG_W) ? (SW + 10) : INTEG_W) + 1;
   // P + I - D without overflow
   localparam int SUM_W = (((SW + 7) > 21) ? (SW + 7) : 21) + 2;

   // configuration registers
   logic [CSR_DATA_W-1:0]        prop_gain_ff, integ_gain_ff, deriv_gain_ff;
   logic signed [CSR_DATA_W-1:0] out_max_ff, out_min_ff;

   // per-channel state
   logic signed [INTEG_W-1:0] integral_ff [NUM_CHANNELS];
   logic signed [SW-1:0]      prev_meas_ff [NUM_CHANNELS];

   // input register
   logic                 s1_vld_ff;
   logic                 s1_op_ff;
   logic                 s1_ch_ff;
   logic signed [SW-1:0] s1_err_ff;
   logic signed [SW-1:0] s1_meas_ff;

   // result register
   logic                 rsp_vld_ff;
   logic signed [SW-1:0] rsp_drive_ff, rsp_drive_in;
   logic [1:0]           rsp_status_ff, rsp_status_in;

   // handshake
   logic out_free, s1_adv, s1_load;

   // datapath
   logic [CH_W-1:0]           ch_idx;
   logic signed [INTEG_W-1:0] old_int, integral_in;
   logic signed [SW-1:0]      prev_meas;
   logic signed [16:0]        kp_s, ki_s, kd_s;
   logic signed [SW+16:0]     p_prod, i_prod;
   logic [SW+17:0]            p_rnd, i_rnd;
   logic signed [SW+5:0]      p_val;
   logic signed [SW+9:0]      inc_val;
   logic signed [ACC_W-1:0]   acc;
   logic [INTEG_W:0]          int_rnd;
   logic signed [20:0]        i_val;
   logic signed [SW:0]        diff;
   logic signed [SW+17:0]     d_prod;
   logic [SW+18:0]            d_rnd;
   logic signed [SW+6:0]      d_val;
   logic signed [SUM_W-1:0]   sum, hi_lim, lo_lim, clamped;
   logic [1:0]                status;

   // ---------------------------------------------------------------- handshake
   assign out_free  = !rsp_vld_ff || !rsp_stall;
   assign s1_adv    = s1_vld_ff && out_free;
   assign req_stall = s1_vld_ff && !out_free;
   assign s1_load   = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   // Hold the configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         prop_gain_ff  <= PROP_GAIN_RST;
         integ_gain_ff <= INTEG_GAIN_RST;
         deriv_gain_ff <= DERIV_GAIN_RST;
         out_max_ff    <= OUT_MAX_RST;
         out_min_ff    <= OUT_MIN_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_PROP_GAIN:  prop_gain_ff  <= csr_wdata;
            CSR_INTEG_GAIN: integ_gain_ff <= csr_wdata;
            CSR_DERIV_GAIN: deriv_gain_ff <= csr_wdata;
            CSR_OUT_MAX:    out_max_ff    <= csr_wdata;
            CSR_OUT_MIN:    out_min_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Capture the request transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (s1_load) begin
         s1_vld_ff <= 1'b1;
      end else if (s1_adv) begin
         s1_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_op_ff   <= req_operation;
         s1_ch_ff   <= req_channel;
         s1_err_ff  <= req_error_value;
         s1_meas_ff <= req_measurement;
      end
   end

   // ---------------------------------------------------------------- datapath
   // Channel number wraps onto the implemented channels
   assign ch_idx = (NUM_CHANNELS > 1) ? CH_W'(s1_ch_ff) : '0;

   assign old_int   = integral_ff[ch_idx];
   assign prev_meas = prev_meas_ff[ch_idx];

   assign kp_s = $signed({1'b0, prop_gain_ff});
   assign ki_s = $signed({1'b0, integ_gain_ff});
   assign kd_s = $signed({1'b0, deriv_gain_ff});

   // Proportional term, rounded half up to Q8.8
   assign p_prod = s1_err_ff * kp_s;
   assign p_rnd  = {p_prod[SW+16], p_prod} + (SW+18)'(2048);
   assign p_val  = p_rnd[SW+17:12];

   // Integral increment, rounded half up to Q12.12
   assign i_prod  = s1_err_ff * ki_s;
   assign i_rnd   = {i_prod[SW+16], i_prod} + (SW+18)'(128);
   assign inc_val = i_rnd[SW+17:8];

   // Accumulate and saturate at the integral's range
   assign acc = ACC_W'(inc_val) + ACC_W'(old_int);

   always_comb begin
      if (acc[ACC_W-1:INTEG_W-1] == '0 || acc[ACC_W-1:INTEG_W-1] == '1) begin
         integral_in = acc[INTEG_W-1:0];
      end else if (acc[ACC_W-1]) begin
         integral_in = {1'b1, {(INTEG_W-1){1'b0}}};
      end else begin
         integral_in = {1'b0, {(INTEG_W-1){1'b1}}};
      end
   end

   // Integral term, rounded half up to Q8.8
   assign int_rnd = {integral_in[INTEG_W-1], integral_in} + (INTEG_W+1)'(8);
   assign i_val   = int_rnd[INTEG_W:4];

   // Derivative on measurement, rounded half up to Q8.8
   assign diff   = {s1_meas_ff[SW-1], s1_meas_ff} - {prev_meas[SW-1], prev_meas};
   assign d_prod = diff * kd_s;
   assign d_rnd  = {d_prod[SW+17], d_prod} + (SW+19)'(2048);
   assign d_val  = d_rnd[SW+18:12];

   assign sum    = SUM_W'(p_val) + SUM_W'(i_val) - SUM_W'(d_val);
   assign hi_lim = SUM_W'(out_max_ff);
   assign lo_lim = SUM_W'(out_min_ff);

   // Clamp, high limit tested first
   always_comb begin
      if (sum > hi_lim) begin
         clamped = hi_lim;
         status  = LIMIT_HIGH;
      end else if (sum < lo_lim) begin
         clamped = lo_lim;
         status  = LIMIT_LOW;
      end else begin
         clamped = sum;
         status  = LIMIT_NONE;
      end
   end

   // Select the result; clear returns zero
   always_comb begin
      if (s1_op_ff == OP_CLEAR) begin
         rsp_drive_in  = '0;
         rsp_status_in = LIMIT_NONE;
      end else begin
         rsp_drive_in  = clamped[SW-1:0];
         rsp_status_in = status;
      end
   end

   // Update channel state as the transaction advances
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            integral_ff[i]  <= '0;
            prev_meas_ff[i] <= '0;
         end
      end else if (s1_adv) begin
         if (s1_op_ff == OP_CLEAR) begin
            integral_ff[ch_idx]  <= '0;
            prev_meas_ff[ch_idx] <= '0;
         end else begin
            // drop the increment when the output was clamped
            if (status == LIMIT_NONE) begin
               integral_ff[ch_idx] <= integral_in;
            end
            prev_meas_ff[ch_idx] <= s1_meas_ff;
         end
      end
   end

   // ---------------------------------------------------------------- result
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (s1_adv) begin
         rsp_vld_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_drive_ff  <= rsp_drive_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign rsp_valid        = rsp_vld_ff;
   assign rsp_drive        = rsp_drive_ff;
   assign rsp_limit_status = rsp_status_ff;

endmodule

`default_nettype wire

[sv/dcpid_checker.sv]
// Port-level checks for the dual channel PID regulator, bound to its top level.
// Depends on dcpid_pkg for the configuration and status encodings.
`default_nettype none

module dcpid_checker
   import dcpid_pkg::*;
#(
   parameter int SAMPLE_WIDTH = 16
) (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_stall,
   input logic                    rsp_valid,
   input logic                    rsp_stall,
   input logic [SAMPLE_WIDTH-1:0] rsp_drive,
   input logic [1:0]              rsp_limit_status
);

   // Results drain out of reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // With the output empty there is always room for a request
   a_no_false_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("request stalled while output empty");

   // Limit status is never the unused code
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_limit_status == LIMIT_NONE || rsp_limit_status == LIMIT_HIGH ||
                     rsp_limit_status == LIMIT_LOW))
      else $error("undefined limit status");

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_drive) &&
                                 $stable(rsp_limit_status))
      else $error("stalled result changed");

endmodule

bind dual_channel_pid_antiwindup dcpid_checker #(
   .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_dcpid_checker (
   .clock            (clock),
   .reset            (reset),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_drive        (rsp_drive),
   .rsp_limit_status (rsp_limit_status)
);

`default_nettype wire

[tb/dcpid_checker.sv]
// Scoreboard for the dual channel PID regulator: watches the request, result
// and register write channels, predicts each result and compares it.
// Depends on dcpid_pkg for register indexes, operation and limit status codes.
`timescale 1ns / 1ps

module dcpid_scoreboard
   import dcpid_pkg::*;
#(
   parameter int NUM_CHANNELS = 2,
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  logic                           req_operation,
   input  logic                           req_channel,
   input  logic signed [SAMPLE_WIDTH-1:0] req_error_value,
   input  logic signed [SAMPLE_WIDTH-1:0] req_measurement,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  logic signed [SAMPLE_WIDTH-1:0] rsp_drive,
   input  logic [1:0]                     rsp_limit_status,
   input  logic                           csr_valid,
   input  logic                           csr_ready,
   input  logic [CSR_INDEX_W-1:0]         csr_index,
   input  logic [CSR_DATA_W-1:0]          csr_wdata,
   output int                             pending_results,
   output int                             fail_count
);

   localparam longint INTEG_HI = (longint'(1) <<< (INTEG_W - 1)) - 1;
   localparam longint INTEG_LO = -(longint'(1) <<< (INTEG_W - 1));

   typedef struct {
      logic signed [SAMPLE_WIDTH-1:0] drive;
      limit_type                      status;
   } drive_result_type;

   // Shadow copy of the gains, limits and per-channel regulator state
   logic [CSR_DATA_W-1:0]          kp, ki, kd;
   logic signed [CSR_DATA_W-1:0]   lim_hi, lim_lo;
   logic signed [INTEG_W-1:0]      integ_acc [NUM_CHANNELS];
   logic signed [SAMPLE_WIDTH-1:0] last_meas [NUM_CHANNELS];

   drive_result_type expected_drive_q[$];

   // One regulator step: update the channel state and return the clamped drive
   function automatic drive_result_type regulate_step(input logic op, input logic ch_bit,
         input logic signed [SAMPLE_WIDTH-1:0] err_in,
         input logic signed [SAMPLE_WIDTH-1:0] meas_in);
      int               ch;
      longint           err, meas, prev_int, new_int, p_term, i_term, d_term, total;
      drive_result_type r;
      ch = int'(ch_bit) % NUM_CHANNELS;
      if (op == OP_CLEAR) begin
         integ_acc[ch] = '0;
         last_meas[ch] = '0;
         r.drive = '0;
         r.status = LIMIT_NONE;
         return r;
      end
      err = err_in;
      meas = meas_in;
      prev_int = integ_acc[ch];
      // accumulate with round half up, then saturate to the accumulator range
      new_int = prev_int + ((err * longint'(ki) + 128) >>> 8);
      if (new_int > INTEG_HI) new_int = INTEG_HI;
      if (new_int < INTEG_LO) new_int = INTEG_LO;
      p_term = (err * longint'(kp) + 2048) >>> 12;
      i_term = (new_int + 8) >>> 4;
      d_term = ((meas - longint'(last_meas[ch])) * longint'(kd) + 2048) >>> 12;
      last_meas[ch] = meas_in;
      total = p_term + i_term - d_term;
      // clamp, high side first; a clamped step keeps the old integral
      if (total > longint'(lim_hi)) begin
         r.drive = lim_hi;
         r.status = LIMIT_HIGH;
      end else if (total < longint'(lim_lo)) begin
         r.drive = lim_lo;
         r.status = LIMIT_LOW;
      end else begin
         r.drive = total[SAMPLE_WIDTH-1:0];
         r.status = LIMIT_NONE;
         integ_acc[ch] = new_int[INTEG_W-1:0];
      end
      return r;
   endfunction

   always @(posedge clock) begin
      drive_result_type want;
      if (reset) begin
         kp = PROP_GAIN_RST;
         ki = INTEG_GAIN_RST;
         kd = DERIV_GAIN_RST;
         lim_hi = OUT_MAX_RST;
         lim_lo = OUT_MIN_RST;
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            integ_acc[i] = '0;
            last_meas[i] = '0;
         end
         expected_drive_q.delete();
      end else begin
         // track register writes; unknown indexes are dropped
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_PROP_GAIN:  kp = csr_wdata;
               CSR_INTEG_GAIN: ki = csr_wdata;
               CSR_DERIV_GAIN: kd = csr_wdata;
               CSR_OUT_MAX:    lim_hi = csr_wdata;
               CSR_OUT_MIN:    lim_lo = csr_wdata;
               default: ;
            endcase
         end
         // compare each result transaction with the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            if (expected_drive_q.size() == 0) begin
               $error("unexpected result: drive %0d, limit_status %0d",
                      rsp_drive, rsp_limit_status);
               fail_count++;
            end else begin
               want = expected_drive_q.pop_front();
               if (rsp_drive !== want.drive) begin
                  $error("drive mismatch: expected %0d, actual %0d", want.drive, rsp_drive);
                  fail_count++;
               end
               if (rsp_limit_status !== want.status) begin
                  $error("limit_status mismatch: expected %0d, actual %0d",
                         want.status, rsp_limit_status);
                  fail_count++;
               end
            end
         end
         // predict each accepted request transaction
         if (req_valid && !req_stall)
            expected_drive_q.push_back(regulate_step(req_operation, req_channel,
                                                     req_error_value, req_measurement));
      end
      pending_results = expected_drive_q.size();
   end

endmodule

[tb/tb.sv]
// Top of the dual channel PID regulator testbench: clock, reset, stimulus and
// verdict. Depends on dcpid_pkg, dual_channel_pid_antiwindup and dcpid_scoreboard.
`timescale 1ns / 1ps

module tb;
   import dcpid_pkg::*;

   localparam int NUM_CHANNELS = 2;
   localparam int SW           = 16;
   localparam int HOLD_CYCLES  = 96;
   localparam int BLOCK_ITEMS  = 165;
   localparam logic signed [SW-1:0] SAMPLE_MAX = {1'b0, {(SW-1){1'b1}}};
   localparam logic signed [SW-1:0] SAMPLE_MIN = {1'b1, {(SW-1){1'b0}}};

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic                   req_operation = 1'b0;
   logic                   req_channel = 1'b0;
   logic signed [SW-1:0]   req_error_value = '0;
   logic signed [SW-1:0]   req_measurement = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic signed [SW-1:0]   rsp_drive;
   logic [1:0]             rsp_limit_status;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;
   int                     pending_results;
   int                     fail_count;

   int                     send_idle_pct = 0;
   int                     recv_idle_pct = 0;
   logic                   hold_request = 1'b0;
   int                     hold_left = 0;
   logic signed [SW-1:0]   last_meas_sent [NUM_CHANNELS] = '{default: '0};

   always #10 clock = ~clock;

   dual_channel_pid_antiwindup #(
      .NUM_CHANNELS(NUM_CHANNELS),
      .SAMPLE_WIDTH(SW)
   ) u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_operation(req_operation), .req_channel(req_channel),
      .req_error_value(req_error_value), .req_measurement(req_measurement),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_drive(rsp_drive), .rsp_limit_status(rsp_limit_status),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   dcpid_scoreboard #(
      .NUM_CHANNELS(NUM_CHANNELS),
      .SAMPLE_WIDTH(SW)
   ) u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_operation(req_operation), .req_channel(req_channel),
      .req_error_value(req_error_value), .req_measurement(req_measurement),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_drive(rsp_drive), .rsp_limit_status(rsp_limit_status),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata),
      .pending_results(pending_results), .fail_count(fail_count)
   );

   // Result side back-pressure: random stalls, or a long hold when requested
   initial begin
      forever begin
         @(negedge clock);
         if (hold_request && hold_left == 0) begin
            hold_left = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   // Hard stop in case the block hangs
   initial begin
      #5_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   // Offer one request transaction, after a random idle gap, and hold it until taken
   task automatic send_item(input op_type op, input logic ch,
                            input logic signed [SW-1:0] err,
                            input logic signed [SW-1:0] meas);
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_operation <= op;
      req_channel <= ch;
      req_error_value <= err;
      req_measurement <= meas;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic apply_settings(input logic [CSR_DATA_W-1:0] kp, ki, kd,
                                 input logic signed [CSR_DATA_W-1:0] hi, lo);
      write_csr(CSR_PROP_GAIN, kp);
      write_csr(CSR_INTEG_GAIN, ki);
      write_csr(CSR_DERIV_GAIN, kd);
      write_csr(CSR_OUT_MAX, hi);
      write_csr(CSR_OUT_MIN, lo);
   endtask

   // Drop valid and wait until every predicted result has come back
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results != 0) @(negedge clock);
      repeat (2) @(negedge clock);
   endtask

   function automatic logic signed [SW-1:0] pick_sample();
      case ($urandom_range(9))
         0:       return SAMPLE_MAX;
         1:       return SAMPLE_MIN;
         2, 3, 4: return SW'(int'($urandom_range(1024)) - 512);
         default: return SW'($urandom());
      endcase
   endfunction

   // Random step or clear; half the time measurements drift slowly like a real wheel
   task automatic send_random_item();
      op_type               op;
      logic                 ch;
      logic signed [SW-1:0] err;
      logic signed [SW-1:0] meas;
      op = ($urandom_range(99) < 6) ? OP_CLEAR : OP_STEP;
      ch = 1'($urandom_range(1));
      err = pick_sample();
      if ($urandom_range(1))
         meas = last_meas_sent[ch] + SW'(int'($urandom_range(128)) - 64);
      else
         meas = pick_sample();
      last_meas_sent[ch] = (op == OP_STEP) ? meas : '0;
      send_item(op, ch, err, meas);
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // writes to unused indexes must leave the reset gains in place
      for (int idx = int'(CSR_OUT_MIN) + 1; idx < (1 << CSR_INDEX_W); idx++)
         write_csr(CSR_INDEX_W'(idx), CSR_DATA_W'($urandom()));

      // directed: clears, zero input, both clamp sides, rounding near zero
      send_item(OP_CLEAR, 1'b0, SAMPLE_MAX, SAMPLE_MIN);
      send_item(OP_CLEAR, 1'b1, SAMPLE_MIN, SAMPLE_MAX);
      send_item(OP_STEP, 1'b0, '0, '0);
      send_item(OP_STEP, 1'b0, SAMPLE_MAX, '0);
      send_item(OP_STEP, 1'b0, SAMPLE_MAX, SAMPLE_MIN);
      send_item(OP_STEP, 1'b0, SAMPLE_MIN, SAMPLE_MAX);
      send_item(OP_STEP, 1'b1, 16'sd256, 16'sd256);
      send_item(OP_STEP, 1'b1, -16'sd1, -16'sd1);
      send_item(OP_STEP, 1'b1, 16'sd1, 16'sd1);
      send_item(OP_STEP, 1'b1, -16'sd256, '0);
      send_item(OP_CLEAR, 1'b0, '0, '0);
      send_item(OP_STEP, 1'b0, 16'sd100, 16'sd100);
      wait_idle();

      // integral saturation on both sides: a large derivative term keeps the
      // sum inside the limits so the anti-windup does not undo the addition
      apply_settings(16'd0, 16'hFFFF, 16'd32768, SAMPLE_MAX, SAMPLE_MIN);
      send_item(OP_STEP, 1'b0, '0, SAMPLE_MIN);
      send_item(OP_STEP, 1'b0, SAMPLE_MAX, SAMPLE_MAX);
      send_item(OP_STEP, 1'b0, '0, SAMPLE_MIN);
      send_item(OP_STEP, 1'b0, SAMPLE_MAX, SAMPLE_MAX);
      send_item(OP_STEP, 1'b1, '0, SAMPLE_MAX);
      send_item(OP_STEP, 1'b1, SAMPLE_MIN, SAMPLE_MIN);
      send_item(OP_STEP, 1'b1, '0, SAMPLE_MAX);
      send_item(OP_STEP, 1'b1, SAMPLE_MIN, SAMPLE_MIN);
      wait_idle();

      // crossed limits: the high side wins
      apply_settings(PROP_GAIN_RST, INTEG_GAIN_RST, DERIV_GAIN_RST, -16'sd256, 16'sd256);
      send_item(OP_STEP, 1'b0, SAMPLE_MAX, '0);
      send_item(OP_STEP, 1'b0, SAMPLE_MIN, '0);
      send_item(OP_STEP, 1'b1, '0, '0);
      wait_idle();
      last_meas_sent[0] = '0;
      last_meas_sent[1] = '0;
      send_item(OP_CLEAR, 1'b0, '0, '0);
      send_item(OP_CLEAR, 1'b1, '0, '0);

      // random blocks, each under its own gains and limits; idle patterns are shared in pairs
      for (int blk = 0; blk < 6; blk++) begin
         wait_idle();
         case (blk)
            0: apply_settings(CSR_DATA_W'($urandom_range(8191)),
                              CSR_DATA_W'($urandom_range(1023)),
                              CSR_DATA_W'($urandom_range(8191)), 16'sd25600, -16'sd25600);
            1: apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, SAMPLE_MAX, SAMPLE_MIN);
            2: apply_settings(16'd0, 16'd0, 16'd0, '0, '0);
            3: apply_settings(CSR_DATA_W'($urandom()), CSR_DATA_W'($urandom()),
                              CSR_DATA_W'($urandom()), -16'sd256, 16'sd256);
            4: apply_settings(CSR_DATA_W'($urandom()), CSR_DATA_W'($urandom()),
                              CSR_DATA_W'($urandom()), CSR_DATA_W'($urandom()),
                              CSR_DATA_W'($urandom()));
            default: apply_settings(PROP_GAIN_RST, INTEG_GAIN_RST, DERIV_GAIN_RST,
                                    OUT_MAX_RST, OUT_MIN_RST);
         endcase
         if (blk < 2) begin
            send_idle_pct = 35;
            recv_idle_pct = 85;
         end else if (blk < 4) begin
            send_idle_pct = 85;
            recv_idle_pct = 35;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         // long result hold while requests keep coming, to fill the pipeline
         if (blk == 4) hold_request = 1'b1;
         repeat (BLOCK_ITEMS) send_random_item();
      end

      wait_idle();
      repeat (8) @(negedge clock);
      if (fail_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

[filelist.f]
sv/dcpid_pkg.sv
sv/dual_channel_pid_antiwindup.sv
sv/dcpid_checker.sv
tb/dcpid_checker.sv
tb/tb.sv
